>>> src/hlp_pkg.sv
package hlp_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int SIZE_W      = 4;
   localparam int VALUE_W     = 31;
   localparam int KEY_W       = 64;

   localparam logic [KEY_W-1:0] KEY_EMPTY  = 64'h0000_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_TOMB   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [KEY_W-1:0] MIX_C1     = 64'hff51_afd7_ed55_8ccd;
   localparam logic [KEY_W-1:0] MIX_C2     = 64'hc4ce_b9fe_1a85_ec53;
   localparam int               MIX_SHIFT  = 33;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_FIND   = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_BAD      = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [ADDR_W-1:0]  pos;
   } hlp_job_type;

   // Effective log2 of the slot count: zero taken as one, clamped to the store.
   function automatic logic [SIZE_W-1:0] eff_log2(input logic [SIZE_W-1:0] lg);
      logic [SIZE_W-1:0] r;
      r = lg;
      if (r == '0) begin
         r = SIZE_W'(1);
      end
      if (32'(r) > ADDR_W) begin
         r = SIZE_W'(ADDR_W);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] slot_count(input logic [SIZE_W-1:0] lg);
      return CNT_W'(1) << eff_log2(lg);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_mask(input logic [SIZE_W-1:0] lg);
      logic [CNT_W-1:0] n;
      n = slot_count(lg) - CNT_W'(1);
      return n[ADDR_W-1:0];
   endfunction

endpackage

>>> src/hlp_if.sv
interface hlp_req_if
   import hlp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [7:0]         volume_num;
   logic [47:0]        file_id;
   logic [VALUE_W-1:0] entry_value;
   modport source (output valid, func, volume_num, file_id, entry_value, input ready);
   modport sink   (input valid, func, volume_num, file_id, entry_value, output ready);
endinterface

interface hlp_rsp_if
   import hlp_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [VALUE_W-1:0] found_value;
   modport source (output valid, status, found_value, input ready);
   modport sink   (input valid, status, found_value, output ready);
endinterface

interface hlp_csr_if
   import hlp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] size_log2;
   modport source (output valid, size_log2, input ready);
   modport sink   (input valid, size_log2, output ready);
endinterface

>>> src/hlp_ram.sv
module hlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/hlp_front.sv
module hlp_front
   import hlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   hlp_req_if.sink           req,
   input  logic [ADDR_W-1:0] mask,
   output logic              push_valid,
   input  logic              push_ready,
   output hlp_job_type       push_job
);

   localparam logic [2:0] FS_IDLE = 3'd0;
   localparam logic [2:0] FS_MUL1 = 3'd1;
   localparam logic [2:0] FS_SUM1 = 3'd2;
   localparam logic [2:0] FS_MUL2 = 3'd3;
   localparam logic [2:0] FS_SUM2 = 3'd4;
   localparam logic [2:0] FS_PUSH = 3'd5;

   logic [2:0]       state_ff, state_in;
   hlp_job_type      job_ff, job_in;
   logic [KEY_W-1:0] k_ff, k_in;
   logic [63:0]      plo_ff;
   logic [31:0]      pa_ff, pb_ff;
   logic [KEY_W-1:0] cst, key, msum;

   assign cst  = (state_ff == FS_MUL2) ? MIX_C2 : MIX_C1;
   assign key  = {16'(req.volume_num) + 16'd1, req.file_id};
   assign msum = plo_ff + {pa_ff + pb_ff, 32'd0};

   assign req.ready  = (state_ff == FS_IDLE);
   assign push_valid = (state_ff == FS_PUSH);
   assign push_job   = job_ff;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      k_in     = k_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (req.valid) begin
               job_in.func  = req.func;
               job_in.key   = key;
               job_in.value = req.entry_value;
               k_in         = key ^ (key >> MIX_SHIFT);
               state_in     = FS_MUL1;
            end
         end
         FS_MUL1: state_in = FS_SUM1;
         FS_SUM1: begin
            k_in     = msum ^ (msum >> MIX_SHIFT);
            state_in = FS_MUL2;
         end
         FS_MUL2: state_in = FS_SUM2;
         FS_SUM2: begin
            k_in       = msum ^ (msum >> MIX_SHIFT);
            job_in.pos = k_in[ADDR_W-1:0] & mask;
            state_in   = FS_PUSH;
         end
         FS_PUSH: begin
            if (push_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff <= job_in;
      k_ff   <= k_in;
      // split 64x64 low product into three 32x32 partials
      plo_ff <= {32'd0, k_ff[31:0]} * {32'd0, cst[31:0]};
      pa_ff  <= k_ff[63:32] * cst[31:0];
      pb_ff  <= k_ff[31:0] * cst[63:32];
   end

endmodule

>>> src/hlp_queue.sv
module hlp_queue
   import hlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  hlp_job_type push_job,
   output logic        pop_valid,
   input  logic        pop_ready,
   output hlp_job_type pop_job
);

   hlp_job_type slot_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  count_ff;
   logic        do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= ~rptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

>>> src/hlp_back.sv
module hlp_back
   import hlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  hlp_job_type       pop_job,
   input  logic [ADDR_W-1:0] mask,
   input  logic [CNT_W-1:0]  count,
   hlp_rsp_if.source         rsp
);

   localparam logic [2:0] BS_CLEAR = 3'd0;
   localparam logic [2:0] BS_IDLE  = 3'd1;
   localparam logic [2:0] BS_READ  = 3'd2;
   localparam logic [2:0] BS_CHECK = 3'd3;
   localparam logic [2:0] BS_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   hlp_job_type        job_ff, job_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               have_ff, have_in;
   logic [ADDR_W-1:0]  tomb_ff, tomb_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [1:0]         status_ff, status_in;
   logic [VALUE_W-1:0] found_ff, found_in;
   logic               rvalid_ff, rvalid_in;
   logic [1:0]         rstatus_ff, rstatus_in;
   logic [VALUE_W-1:0] rfound_ff, rfound_in;

   logic               kwe, vwe;
   logic [ADDR_W-1:0]  kwaddr, vwaddr;
   logic [KEY_W-1:0]   kwdata, krdata;
   logic [VALUE_W-1:0] vrdata;
   logic               is_match, is_empty, is_tomb, last, tomb_any;
   logic [ADDR_W-1:0]  tomb_at;

   hlp_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock, .we(kwe), .waddr(kwaddr), .wdata(kwdata),
      .raddr(job_ff.pos), .rdata(krdata)
   );

   hlp_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_value_ram (
      .clock, .we(vwe), .waddr(vwaddr), .wdata(job_ff.value),
      .raddr(job_ff.pos), .rdata(vrdata)
   );

   assign is_match = (krdata == job_ff.key);
   assign is_empty = (krdata == KEY_EMPTY);
   assign is_tomb  = (krdata == KEY_TOMB);
   assign last     = ((cnt_ff + CNT_W'(1)) == count);
   assign tomb_any = have_ff || is_tomb;
   assign tomb_at  = have_ff ? tomb_ff : job_ff.pos;

   assign pop_ready       = (state_ff == BS_IDLE);
   assign rsp.valid       = rvalid_ff;
   assign rsp.status      = rstatus_ff;
   assign rsp.found_value = rfound_ff;

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      cnt_in     = cnt_ff;
      have_in    = have_ff;
      tomb_in    = tomb_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      rvalid_in  = rvalid_ff && !rsp.ready;
      rstatus_in = rstatus_ff;
      rfound_in  = rfound_ff;
      kwe        = 1'b0;
      kwaddr     = job_ff.pos;
      kwdata     = job_ff.key;
      vwe        = 1'b0;
      vwaddr     = job_ff.pos;
      unique case (state_ff)
         BS_CLEAR: begin
            kwe    = 1'b1;
            kwaddr = clr_ff;
            kwdata = KEY_EMPTY;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               status_in = STATUS_OK;
               found_in  = '0;
               state_in  = clr_rsp_ff ? BS_DONE : BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (pop_valid) begin
               job_in     = pop_job;
               cnt_in     = '0;
               have_in    = 1'b0;
               clr_rsp_in = 1'b1;
               clr_in     = '0;
               state_in   = (pop_job.func == FUNC_CLEAR) ? BS_CLEAR : BS_READ;
            end
         end
         BS_READ: state_in = BS_CHECK;
         BS_CHECK: begin
            status_in = STATUS_NOTFOUND;
            found_in  = '0;
            state_in  = BS_DONE;
            if (job_ff.func == FUNC_INSERT) begin
               if (is_tomb && !have_ff) begin
                  have_in = 1'b1;
                  tomb_in = job_ff.pos;
               end
               priority if (is_match) begin
                  vwe       = 1'b1;
                  status_in = STATUS_OK;
               end else if (is_empty) begin
                  kwe       = 1'b1;
                  vwe       = 1'b1;
                  kwaddr    = tomb_at;
                  vwaddr    = tomb_at;
                  status_in = STATUS_OK;
               end else if (last) begin
                  // no empty slot on a full pass: fall back to the first tombstone
                  kwe       = tomb_any;
                  vwe       = tomb_any;
                  kwaddr    = tomb_at;
                  vwaddr    = tomb_at;
                  status_in = tomb_any ? STATUS_OK : STATUS_FULL;
               end else begin
                  cnt_in     = cnt_ff + CNT_W'(1);
                  job_in.pos = (job_ff.pos + ADDR_W'(1)) & mask;
                  state_in   = BS_READ;
               end
            end else begin
               priority if (is_empty) begin
                  status_in = STATUS_NOTFOUND;
               end else if (is_match) begin
                  status_in = STATUS_OK;
                  if (job_ff.func == FUNC_FIND) begin
                     found_in = vrdata;
                  end else begin
                     kwe    = 1'b1;
                     kwdata = KEY_TOMB;
                  end
               end else if (!last) begin
                  cnt_in     = cnt_ff + CNT_W'(1);
                  job_in.pos = (job_ff.pos + ADDR_W'(1)) & mask;
                  state_in   = BS_READ;
               end
            end
         end
         BS_DONE: begin
            if (!rvalid_ff || rsp.ready) begin
               rvalid_in  = 1'b1;
               rstatus_in = status_ff;
               rfound_in  = found_ff;
               state_in   = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BS_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         rvalid_ff  <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         rvalid_ff  <= rvalid_in;
         have_ff    <= have_in;
      end
      job_ff     <= job_in;
      cnt_ff     <= cnt_in;
      tomb_ff    <= tomb_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      rstatus_ff <= rstatus_in;
      rfound_ff  <= rfound_in;
   end

endmodule

>>> src/ref_hash_table_linear_probe_top.sv
// Hash map from (volume, file reference) to a 31-bit entry index, held in an
// open-addressing table of 4096 slots with linear probing and tombstones. Each
// req_ word carries one operation (insert or update, find, remove, clear all)
// and yields exactly one rsp_ word with a status and, for a successful find,
// the stored value. The front end builds the 64-bit key and runs the murmur
// finaliser on a shared set of 32x32 multipliers, through the states MUL1,
// SUM1, MUL2, SUM2 and PUSH, into the two-deep queue. The back end walks
// the key memory, which has one registered read port, so each slot probed
// takes a READ and then a CHECK state; a lookup probes up to the slot count
// on a full table before DONE. A clear sweeps the whole key store at one
// slot a cycle. After reset the same clearing pass runs before the first
// job is served; words are still taken until the queue fills. The csr_
// port writes size_log2, which is only to be changed while the block holds
// no outstanding work.
module ref_hash_table_linear_probe_top
   import hlp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hlp_req_if.sink   req_ch,
   hlp_rsp_if.source rsp_ch,
   hlp_csr_if.sink   csr_ch
);

   logic [SIZE_W-1:0] size_ff;
   logic [ADDR_W-1:0] mask;
   logic [CNT_W-1:0]  count;
   logic              push_valid, push_ready, pop_valid, pop_ready;
   hlp_job_type       push_job, pop_job;

   // config register: always ready, hold the written word
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(12);
      end else if (csr_ch.valid) begin
         size_ff <= csr_ch.size_log2;
      end
   end

   // probe mask derived once for both halves, probe limit for the back end
   assign mask  = slot_mask(size_ff);
   assign count = slot_count(size_ff);

   hlp_front u_front (
      .clock, .reset, .req(req_ch), .mask,
      .push_valid, .push_ready, .push_job
   );

   hlp_queue u_queue (
      .clock, .reset, .push_valid, .push_ready, .push_job,
      .pop_valid, .pop_ready, .pop_job
   );

   hlp_back u_back (
      .clock, .reset, .pop_valid, .pop_ready, .pop_job,
      .mask, .count, .rsp(rsp_ch)
   );

endmodule

>>> src/hlp_checker.sv
module hlp_checker
   import hlp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [VALUE_W-1:0] rsp_found
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != STATUS_BAD)
      else $error("bad status code");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_found == '0)
      else $error("value shown on failed operation");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word after reset");

endmodule

bind ref_hash_table_linear_probe_top hlp_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_status(rsp_ch.status),
   .rsp_found(rsp_ch.found_value)
);

>>> tb/ref_hash_table_linear_probe_top_tb.sv
`timescale 1ns / 1ps

module ref_hash_table_linear_probe_top_tb;
   import hlp_pkg::*;

   typedef struct {
      logic [1:0]         status;
      logic [VALUE_W-1:0] found_value;
   } lookup_result_type;

   logic clock;
   logic reset;

   hlp_req_if req_ch ();
   hlp_rsp_if rsp_ch ();
   hlp_csr_if csr_ch ();

   ref_hash_table_linear_probe_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the table and of the size register.
   logic [KEY_W-1:0]   shadow_keys   [TABLE_DEPTH];
   logic [VALUE_W-1:0] shadow_values [TABLE_DEPTH];
   logic [SIZE_W-1:0]  shadow_size;

   lookup_result_type pending_results[$];
   logic [55:0]       key_pool[$];   // {volume, file reference}

   int  error_count;
   int  words_sent;
   int  words_checked;
   int  full_seen;
   int  notfound_seen;
   bit  idle_on;
   int  hold_request;
   int  hold_left;

   // Clock: 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Murmur finaliser, low 32 bits.
   function automatic logic [31:0] murmur_mix(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] m;
      m = k;
      m = m ^ (m >> MIX_SHIFT);
      m = m * MIX_C1;
      m = m ^ (m >> MIX_SHIFT);
      m = m * MIX_C2;
      m = m ^ (m >> MIX_SHIFT);
      return m[31:0];
   endfunction

   // Slots in use: zero counts as one, anything above the store clamps to it.
   function automatic int slots_in_use(input logic [SIZE_W-1:0] lg);
      int l;
      l = int'(lg);
      if (l < 1) begin
         l = 1;
      end
      if (l > ADDR_W) begin
         l = ADDR_W;
      end
      return 1 << l;
   endfunction

   // Apply one operation to the shadow table and return what the block must answer.
   function automatic lookup_result_type apply_operation(input logic [1:0] func,
                                                         input logic [7:0] vol,
                                                         input logic [47:0] fref,
                                                         input logic [VALUE_W-1:0] val);
      lookup_result_type res;
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  cur;
      int                n;
      int                pos;
      int                tomb;
      bit                have_tomb;
      bit                done;
      key           = {({8'd0, vol} + 16'd1), fref};
      n             = slots_in_use(shadow_size);
      pos           = int'(murmur_mix(key)) & (n - 1);
      res.status    = STATUS_NOTFOUND;
      res.found_value = '0;
      have_tomb     = 1'b0;
      tomb          = 0;
      done          = 1'b0;
      if (func == FUNC_CLEAR) begin
         for (int i = 0; i < TABLE_DEPTH; i++) shadow_keys[i] = KEY_EMPTY;
         res.status = STATUS_OK;
      end else if (func == FUNC_INSERT) begin
         for (int p = 0; p < n && !done; p++) begin
            cur = shadow_keys[pos];
            if (cur == key) begin
               shadow_values[pos] = val;
               done = 1'b1;
            end else begin
               if (cur == KEY_TOMB && !have_tomb) begin
                  have_tomb = 1'b1;
                  tomb      = pos;
               end
               if (cur == KEY_EMPTY) begin
                  if (!have_tomb) tomb = pos;
                  shadow_keys[tomb]   = key;
                  shadow_values[tomb] = val;
                  done = 1'b1;
               end
               pos = (pos + 1) & (n - 1);
            end
         end
         // No empty slot on the whole path: fall back to the first tombstone.
         if (!done && have_tomb) begin
            shadow_keys[tomb]   = key;
            shadow_values[tomb] = val;
            done = 1'b1;
         end
         res.status = done ? STATUS_OK : STATUS_FULL;
      end else begin
         for (int p = 0; p < n && !done; p++) begin
            cur = shadow_keys[pos];
            if (cur == KEY_EMPTY) begin
               done = 1'b1;
            end else if (cur == key) begin
               res.status = STATUS_OK;
               if (func == FUNC_FIND) res.found_value = shadow_values[pos];
               else shadow_keys[pos] = KEY_TOMB;
               done = 1'b1;
            end
            pos = (pos + 1) & (n - 1);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint expv, input longint gotv);
      $display("error %0t: %s expected %0h got %0h", $realtime, what, expv, gotv);
      error_count++;
   endtask

   // Send one word on req_ch; predict at the accepting edge.
   task automatic send_word(input logic [1:0] func, input logic [7:0] vol,
                            input logic [47:0] fref, input logic [VALUE_W-1:0] val);
      @(negedge clock);
      if (idle_on) begin
         while ($urandom_range(99) < 34) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.volume_num  <= vol;
      req_ch.file_id     <= fref;
      req_ch.entry_value <= val;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(apply_operation(func, vol, fref, val));
      words_sent++;
   endtask

   // Drop valid and wait until every expected word has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Write size_log2; only called with the block idle.
   task automatic write_size(input logic [SIZE_W-1:0] lg);
      drain_results();
      csr_ch.valid     <= 1'b1;
      csr_ch.size_log2 <= lg;
      do @(posedge clock); while (!csr_ch.ready);
      shadow_size = lg;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic void refill_pool(input int count);
      key_pool.delete();
      for (int i = 0; i < count; i++) begin
         key_pool.push_back({8'($urandom), 16'($urandom), 32'($urandom)});
      end
   endfunction

   task automatic send_random(input bit noise_ok);
      logic [55:0] k;
      logic [1:0]  func;
      int          pick;
      pick = $urandom_range(999);
      if (pick < 3)        func = FUNC_CLEAR;
      else if (pick < 430) func = FUNC_INSERT;
      else if (pick < 730) func = FUNC_FIND;
      else                 func = FUNC_REMOVE;
      if (noise_ok && $urandom_range(99) < 15) begin
         k = {8'($urandom), 16'($urandom), 32'($urandom)};
      end else begin
         k = key_pool[$urandom_range(key_pool.size() - 1)];
      end
      send_word(func, k[55:48], k[47:0], VALUE_W'($urandom));
   endtask

   // Ready on the result side: random stalls, plus a counted hold-off on request.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(idle_on && $urandom_range(99) < 34);
      end
   end

   // Check each result word against the oldest expectation.
   always @(posedge clock) begin
      lookup_result_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word, status", 0, rsp_ch.status);
         end else begin
            exp_res = pending_results.pop_front();
            words_checked++;
            if (exp_res.status == STATUS_FULL) full_seen++;
            if (exp_res.status == STATUS_NOTFOUND) notfound_seen++;
            if (rsp_ch.status !== exp_res.status) begin
               report_mismatch("status", exp_res.status, rsp_ch.status);
            end
            if (rsp_ch.found_value !== exp_res.found_value) begin
               report_mismatch("found_value", exp_res.found_value, rsp_ch.found_value);
            end
         end
      end
   end

   // Extremes of the key and value fields, every operation, at the reset size.
   task automatic test_basic_ops();
      send_word(FUNC_FIND,   8'h00, 48'h0, '0);
      send_word(FUNC_INSERT, 8'h00, 48'h0, '0);
      send_word(FUNC_INSERT, 8'hFF, 48'hFFFF_FFFF_FFFF, '1);
      send_word(FUNC_FIND,   8'h00, 48'h0, '1);
      send_word(FUNC_FIND,   8'hFF, 48'hFFFF_FFFF_FFFF, '0);
      send_word(FUNC_INSERT, 8'hFF, 48'hFFFF_FFFF_FFFF, 31'h2AAA_5555);
      send_word(FUNC_FIND,   8'hFF, 48'hFFFF_FFFF_FFFF, '0);
      send_word(FUNC_REMOVE, 8'h00, 48'h0, '1);
      send_word(FUNC_REMOVE, 8'h00, 48'h0, '0);
      send_word(FUNC_FIND,   8'h00, 48'h0, '0);
      send_word(FUNC_CLEAR,  8'hA5, 48'h5A5A_5A5A_5A5A, '1);
      send_word(FUNC_FIND,   8'hFF, 48'hFFFF_FFFF_FFFF, '0);
   endtask

   // Two-slot table: full insert, tombstone reuse after a full probe, misses.
   task automatic test_full_table();
      write_size(4'd0);
      send_word(FUNC_INSERT, 8'd1, 48'd10, 31'd100);
      send_word(FUNC_INSERT, 8'd2, 48'd20, 31'd200);
      send_word(FUNC_INSERT, 8'd3, 48'd30, 31'd300);
      send_word(FUNC_FIND,   8'd3, 48'd30, '0);
      send_word(FUNC_REMOVE, 8'd3, 48'd30, '0);
      send_word(FUNC_REMOVE, 8'd1, 48'd10, '0);
      send_word(FUNC_INSERT, 8'd3, 48'd30, 31'd301);
      send_word(FUNC_FIND,   8'd3, 48'd30, '0);
      send_word(FUNC_FIND,   8'd2, 48'd20, '0);
      write_size(4'd1);
      send_word(FUNC_INSERT, 8'd2, 48'd20, 31'd202);
      send_word(FUNC_FIND,   8'd2, 48'd20, '0);
      send_word(FUNC_CLEAR,  8'd0, 48'd0, '0);
   endtask

   // Sizes above the store clamp to it.
   task automatic test_size_clamp();
      write_size(4'd15);
      send_word(FUNC_INSERT, 8'd7, 48'h1234_5678_9ABC, 31'd7);
      send_word(FUNC_FIND,   8'd7, 48'h1234_5678_9ABC, '0);
      write_size(4'd13);
      send_word(FUNC_FIND,   8'd7, 48'h1234_5678_9ABC, '0);
   endtask

   // Random phases, mostly on small tables where probing wraps and fills up.
   task automatic test_random_phases();
      int lg;
      for (int phase = 0; phase < 11; phase++) begin
         if (phase == 5) lg = 12;
         else if (phase == 8) lg = 8;
         else lg = $urandom_range(1, 5);
         write_size(SIZE_W'(lg));
         refill_pool((1 << lg) + 3 > 40 ? 40 : (1 << lg) + 3);
         idle_on = (phase != 3);   // one long run with no idling on either side
         for (int i = 0; i < 95; i++) send_random(1'b1);
      end
      idle_on = 1'b1;
   endtask

   // Hold the result side off so the block fills and stalls its input.
   task automatic test_backpressure();
      write_size(4'd3);
      refill_pool(10);
      hold_request = 400;
      for (int i = 0; i < 20; i++) send_random(1'b0);
      drain_results();   // sender pauses here until everything has come back
      for (int i = 0; i < 20; i++) send_random(1'b0);
   endtask

   initial begin
      error_count   = 0;
      words_sent    = 0;
      words_checked = 0;
      full_seen     = 0;
      notfound_seen = 0;
      idle_on       = 1'b1;
      hold_request  = 0;
      hold_left     = 0;
      shadow_size   = 4'd12;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_keys[i]   = KEY_EMPTY;
         shadow_values[i] = '0;
      end
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_INSERT;
      req_ch.volume_num  = '0;
      req_ch.file_id     = '0;
      req_ch.entry_value = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.size_log2   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_full_table();
      test_size_clamp();
      test_random_phases();
      test_backpressure();

      drain_results();
      $display("covered %0d words on sizes 0 to 15 incl. clamping, clear, tombstones",
               words_checked);
      $display("table-full answers %0d, not-found answers %0d, words sent %0d",
               full_seen, notfound_seen, words_sent);
      if (error_count == 0) begin
         $display("ref_hash_table_linear_probe_top: match");
      end else begin
         $display("ref_hash_table_linear_probe_top: mismatch");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("timeout with %0d words outstanding", pending_results.size());
      $display("ref_hash_table_linear_probe_top: mismatch");
      $finish;
   end

endmodule
